FILE: hdl/ovn_pkg.sv
package ovn_pkg;

  // Width of the result and of one table entry.
  localparam int unsigned OutW = 16;
  // Guard bits on the octave sum, enough for sixteen octaves.
  localparam int unsigned SumGuardW = 4;
  // Width of the octave count register.
  localparam int unsigned CountW = 5;
  // Reciprocal scaling used by the final divide by the octave count.
  localparam int unsigned RecipShift = 26;
  localparam int unsigned RecipW = RecipShift + 1;
  // Register indexes of the configuration port.
  localparam logic RegOctaveCount = 1'b0;

  // Noise table of 8-bit codes, row major (row is y, column is x).
  localparam logic [7:0] NoiseCodes [64] = '{
    8'd141, 8'd13,  8'd121, 8'd187, 8'd2,   8'd0,   8'd207, 8'd132,
    8'd93,  8'd188, 8'd213, 8'd0,   8'd0,   8'd205, 8'd255, 8'd93,
    8'd217, 8'd14,  8'd255, 8'd0,   8'd177, 8'd255, 8'd245, 8'd217,
    8'd198, 8'd201, 8'd204, 8'd255, 8'd142, 8'd47,  8'd220, 8'd200,
    8'd212, 8'd109, 8'd235, 8'd93,  8'd0,   8'd176, 8'd91,  8'd211,
    8'd8,   8'd152, 8'd242, 8'd230, 8'd184, 8'd255, 8'd213, 8'd3,
    8'd251, 8'd134, 8'd33,  8'd185, 8'd4,   8'd255, 8'd0,   8'd255,
    8'd141, 8'd0,   8'd120, 8'd189, 8'd0,   8'd0,   8'd207, 8'd132
  };

  // Table entry in Q0.16: code * 257 is the code repeated in both bytes.
  function automatic logic [OutW-1:0] noise_entry(input logic [2:0] row,
                                                  input logic [2:0] col);
    logic [7:0] code;
    code = NoiseCodes[{row, col}];
    return {code, code};
  endfunction

  // Rounded-up 2^26 / n for n in 1..16; exact for quotients below 2^21.
  function automatic logic [RecipW-1:0] recip(input logic [CountW-1:0] n);
    logic [RecipW-1:0] r;
    case (n)
      5'd1:    r = 27'd67108864;
      5'd2:    r = 27'd33554432;
      5'd3:    r = 27'd22369622;
      5'd4:    r = 27'd16777216;
      5'd5:    r = 27'd13421773;
      5'd6:    r = 27'd11184811;
      5'd7:    r = 27'd9586981;
      5'd8:    r = 27'd8388608;
      5'd9:    r = 27'd7456541;
      5'd10:   r = 27'd6710887;
      5'd11:   r = 27'd6100806;
      5'd12:   r = 27'd5592406;
      5'd13:   r = 27'd5162221;
      5'd14:   r = 27'd4793491;
      5'd15:   r = 27'd4473925;
      5'd16:   r = 27'd4194304;
      default: r = 27'd67108864;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/ovn_cell.sv
module ovn_cell #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned Idx      = 0,
  parameter int unsigned SumW     = 46
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [FracBits-1:0] fx_i,
  input  logic [FracBits-1:0] fy_i,
  input  logic [SumW-1:0]     sum_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [FracBits-1:0] fx_o,
  output logic [FracBits-1:0] fy_o,
  output logic [SumW-1:0]     sum_o
);
  import ovn_pkg::*;

  localparam int unsigned W    = FracBits - 3;
  localparam int unsigned RowW = OutW + W;
  localparam int unsigned OctW = OutW + 2 * W;

  logic [FracBits-1:0] sx, sy;
  logic [2:0]          x0, y0, x1, y1;
  logic [W-1:0]        ax, ay;
  logic [W:0]          one_w, nax;
  logic [RowW:0]       top_full, bot_full;
  logic                ready_a, ready_b;

  logic                va_q, vb_q;
  logic [FracBits-1:0] fx_a_q, fy_a_q, fx_b_q, fy_b_q;
  logic [SumW-1:0]     sum_a_q, sum_b_q, sum_b_d;
  logic [RowW-1:0]     top_q, bot_q;
  logic [W-1:0]        ay_q;
  logic [W:0]          nay;
  logic [OctW:0]       oct_full;

  // Octave shift of the fraction; high bits fall off.
  assign sx = fx_i << Idx;
  assign sy = fy_i << Idx;
  assign x0 = sx[FracBits-1 -: 3];
  assign y0 = sy[FracBits-1 -: 3];
  assign ax = sx[W-1:0];
  assign ay = sy[W-1:0];
  // Neighbor indices clamp at the last row and column.
  assign x1 = (x0 == 3'd7) ? 3'd7 : x0 + 3'd1;
  assign y1 = (y0 == 3'd7) ? 3'd7 : y0 + 3'd1;

  assign one_w = {1'b1, {W{1'b0}}};
  assign nax   = one_w - {1'b0, ax};

  // Horizontal blend of the two rows.
  assign top_full = (RowW+1)'(noise_entry(y0, x0) * nax) + (RowW+1)'(noise_entry(y0, x1) * ax);
  assign bot_full = (RowW+1)'(noise_entry(y1, x0) * nax) + (RowW+1)'(noise_entry(y1, x1) * ax);

  assign ready_b = ~vb_q | ready_i;
  assign ready_a = ~va_q | ready_b;
  assign ready_o = ready_a;

  // First half: row blends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (ready_a) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      fx_a_q  <= fx_i;
      fy_a_q  <= fy_i;
      sum_a_q <= sum_i;
      top_q   <= top_full[RowW-1:0];
      bot_q   <= bot_full[RowW-1:0];
      ay_q    <= ay;
    end
  end

  // Second half: vertical blend and accumulation when this octave is in use.
  assign nay      = one_w - {1'b0, ay_q};
  assign oct_full = (OctW+1)'(top_q * nay) + (OctW+1)'(bot_q * ay_q);

  always_comb begin
    sum_b_d = sum_a_q;
    if (en_i) begin
      sum_b_d = sum_a_q + SumW'(oct_full[OctW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (ready_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && va_q) begin
      fx_b_q  <= fx_a_q;
      fy_b_q  <= fy_a_q;
      sum_b_q <= sum_b_d;
    end
  end

  assign valid_o = vb_q;
  assign fx_o    = fx_b_q;
  assign fy_o    = fy_b_q;
  assign sum_o   = sum_b_q;

endmodule

FILE: hdl/ovn_scale.sv
module ovn_scale #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned SumW     = 46
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ovn_pkg::CountW-1:0] count_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [SumW-1:0]           sum_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [ovn_pkg::OutW-1:0]  value_o
);
  import ovn_pkg::*;

  localparam int unsigned W     = FracBits - 3;
  localparam int unsigned QW    = OutW + SumGuardW;
  localparam int unsigned ProdW = QW + RecipW;

  logic [QW-1:0]    quot;
  logic             vp_q, vo_q;
  logic [ProdW-1:0] prod_q;
  logic [ProdW-RecipShift-1:0] res;
  logic [OutW-1:0]  value_q, value_d;
  logic             ready_p, ready_out;

  // Drop the blend scaling, then divide by the count through its reciprocal.
  assign quot = sum_i[2*W +: QW];

  assign ready_out = ~vo_q | ready_i;
  assign ready_p   = ~vp_q | ready_out;
  assign ready_o   = ready_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ready_p) begin
        vp_q <= valid_i;
      end
      if (ready_out) begin
        vo_q <= vp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_p && valid_i) begin
      prod_q <= ProdW'(quot * recip(count_i));
    end
  end

  // Saturate to full scale.
  assign res = prod_q[ProdW-1:RecipShift];
  always_comb begin
    value_d = res[OutW-1:0];
    if (res > (ProdW-RecipShift)'({OutW{1'b1}})) begin
      value_d = {OutW{1'b1}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_out && vp_q) begin
      value_q <= value_d;
    end
  end

  assign valid_o = vo_q;
  assign value_o = value_q;

endmodule

FILE: hdl/octave_value_noise_2d.sv
// Throughput: one item per cycle unless out_ready_i stalls; each octave
// cell holds two pipeline stages and every stage hands its item on as
// soon as the next one is free.
// Reset clears all pipeline valid bits and sets the octave count to one.
module octave_value_noise_2d #(
  parameter int unsigned MAX_OCTAVES = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] noise_value_o
);
  import ovn_pkg::*;

  localparam int unsigned W    = FRAC_BITS - 3;
  localparam int unsigned SumW = OutW + SumGuardW + 2 * W;

  logic [CountW-1:0] count_q, count_eff;
  logic              reg_sel;

  logic                 valid_c [MAX_OCTAVES+1];
  logic                 ready_c [MAX_OCTAVES+1];
  logic [FRAC_BITS-1:0] fx_c    [MAX_OCTAVES+1];
  logic [FRAC_BITS-1:0] fy_c    [MAX_OCTAVES+1];
  logic [SumW-1:0]      sum_c   [MAX_OCTAVES+1];

  // Configuration register.
  assign reg_sel = (paddr[2] == RegOctaveCount);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(32-CountW){1'b0}}, count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(1);
    end else if (psel && penable && pwrite && reg_sel) begin
      count_q <= pwdata[CountW-1:0];
    end
  end

  // Zero means one octave; counts above the cell count saturate.
  always_comb begin
    count_eff = count_q;
    if (count_q == '0) begin
      count_eff = CountW'(1);
    end else if (count_q > CountW'(MAX_OCTAVES)) begin
      count_eff = CountW'(MAX_OCTAVES);
    end
  end

  // Chain head: fraction bits of the coordinates and an empty sum.
  assign valid_c[0] = in_valid_i;
  assign in_ready_o = ready_c[0];
  assign fx_c[0]    = x_coord_i[FRAC_BITS-1:0];
  assign fy_c[0]    = y_coord_i[FRAC_BITS-1:0];
  assign sum_c[0]   = '0;

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
    ovn_cell #(
      .FracBits(FRAC_BITS),
      .Idx     (g),
      .SumW    (SumW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (CountW'(g) < count_eff),
      .valid_i(valid_c[g]),
      .ready_o(ready_c[g]),
      .fx_i   (fx_c[g]),
      .fy_i   (fy_c[g]),
      .sum_i  (sum_c[g]),
      .valid_o(valid_c[g+1]),
      .ready_i(ready_c[g+1]),
      .fx_o   (fx_c[g+1]),
      .fy_o   (fy_c[g+1]),
      .sum_o  (sum_c[g+1])
    );
  end

  // Average over the octaves and saturate.
  ovn_scale #(
    .FracBits(FRAC_BITS),
    .SumW    (SumW)
  ) u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .count_i(count_eff),
    .valid_i(valid_c[MAX_OCTAVES]),
    .ready_o(ready_c[MAX_OCTAVES]),
    .sum_i  (sum_c[MAX_OCTAVES]),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .value_o(noise_value_o)
  );

endmodule
